FILE: rtl/gh_pkg.sv
// ----------------------------------------------------------------------------
// gh_pkg
// Shared codes and control types for the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gh_pkg;

    // request operation codes
    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_UNREGISTER = 2'd1;
    localparam logic [1:0] OP_RESOLVE    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture request and launch memory reads
        logic commit;  // apply updates and load the result register
    } t_ctrl_cmd;

endpackage

`default_nettype wire

FILE: rtl/gh_ctrl.sv
// ----------------------------------------------------------------------------
// gh_ctrl
// Two-state sequencer: takes a request, then commits it once the result
// register is free. Owns the handshake on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gh_ctrl
    import gh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_ctrl_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;

    // command decode
    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid && i_rst_n;
        o_cmd.commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    end

    // next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/gh_dpath.sv
// ----------------------------------------------------------------------------
// gh_dpath
// Slot memories, free stack and counters. Reads are launched when a request
// is taken; the decision, memory writes and result are made on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module gh_dpath
    import gh_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int GEN_BITS   = 16,
    parameter int TAG_BITS   = 32,
    parameter int IW         = $clog2(SLOT_COUNT),
    parameter int CW         = $clog2(SLOT_COUNT + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    input  wire logic [1:0]          i_operation,
    input  wire logic [TAG_BITS-1:0] i_object_tag,
    input  wire logic [IW-1:0]       i_handle_index,
    input  wire logic [GEN_BITS-1:0] i_handle_generation,
    output logic [1:0]               o_status,
    output logic [IW-1:0]            o_result_index,
    output logic [GEN_BITS-1:0]      o_result_generation,
    output logic [TAG_BITS-1:0]      o_resolved_tag,
    output logic [CW-1:0]            o_live_count
);

    localparam int SW = IW + GEN_BITS;
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);
    localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);

    // memories: free stack entries hold the slot and its next generation
    logic [TAG_BITS-1:0] tag_mem [SLOT_COUNT];
    logic [GEN_BITS-1:0] gen_mem [SLOT_COUNT];
    logic [SW-1:0]       stk_mem [SLOT_COUNT];

    // captured request
    logic [1:0]          r_op;
    logic [TAG_BITS-1:0] r_tag;
    logic [IW-1:0]       r_idx;
    logic [GEN_BITS-1:0] r_gen;

    // registered read data
    logic [TAG_BITS-1:0] r_rd_tag;
    logic [GEN_BITS-1:0] r_rd_gen;
    logic [SW-1:0]       r_rd_stk;

    // counters
    logic [CW-1:0] r_free_depth;
    logic [CW-1:0] n_free_depth;
    logic [CW-1:0] r_slots_in_use;
    logic [CW-1:0] n_slots_in_use;
    logic [CW-1:0] r_object_total;
    logic [CW-1:0] n_object_total;

    // result register
    logic [1:0]          r_status;
    logic [IW-1:0]       r_res_idx;
    logic [GEN_BITS-1:0] r_res_gen;
    logic [TAG_BITS-1:0] r_res_tag;
    logic [CW-1:0]       r_live;

    // commit decision
    logic [1:0]          n_status;
    logic [IW-1:0]       n_res_idx;
    logic [GEN_BITS-1:0] n_res_gen;
    logic [TAG_BITS-1:0] n_res_tag;
    logic                tag_we;
    logic [IW-1:0]       tag_wa;
    logic [TAG_BITS-1:0] tag_wd;
    logic                gen_we;
    logic [IW-1:0]       gen_wa;
    logic [GEN_BITS-1:0] gen_wd;
    logic                stk_we;
    logic [IW-1:0]       stk_wa;
    logic [IW-1:0]       stk_ra;
    logic                in_range;
    logic                gen_match;
    logic [GEN_BITS-1:0] next_gen;

    assign stk_ra    = IW'(r_free_depth - 1'b1);
    assign in_range  = CW'(r_idx) < r_slots_in_use;
    assign gen_match = r_rd_gen == r_gen;
    assign next_gen  = (r_rd_gen + GEN_ONE == '0) ? GEN_ONE : r_rd_gen + GEN_ONE;

    // capture request and launch reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_tag    <= i_object_tag;
            r_idx    <= i_handle_index;
            r_gen    <= i_handle_generation;
            r_rd_tag <= tag_mem[i_handle_index];
            r_rd_gen <= gen_mem[i_handle_index];
            r_rd_stk <= stk_mem[stk_ra];
        end
    end

    // operation decision
    always_comb begin
        n_status       = ST_OK;
        n_res_idx      = '0;
        n_res_gen      = '0;
        n_res_tag      = '0;
        n_free_depth   = r_free_depth;
        n_slots_in_use = r_slots_in_use;
        n_object_total = r_object_total;
        tag_we         = 1'b0;
        tag_wa         = r_idx;
        tag_wd         = '0;
        gen_we         = 1'b0;
        gen_wa         = r_idx;
        gen_wd         = next_gen;
        stk_we         = 1'b0;
        stk_wa         = IW'(r_free_depth);
        unique case (r_op)
            OP_REGISTER: begin
                if (r_tag == '0) begin
                    n_status = ST_INVALID;
                end else if (r_free_depth != '0) begin
                    // reuse the most recently freed slot
                    n_free_depth = r_free_depth - 1'b1;
                    n_res_idx    = r_rd_stk[SW-1:GEN_BITS];
                    n_res_gen    = r_rd_stk[GEN_BITS-1:0];
                end else if (r_slots_in_use != FULL_CNT) begin
                    // fresh slot starts at generation one
                    n_slots_in_use = r_slots_in_use + 1'b1;
                    n_res_idx      = IW'(r_slots_in_use);
                    n_res_gen      = GEN_ONE;
                    gen_we         = 1'b1;
                    gen_wa         = IW'(r_slots_in_use);
                    gen_wd         = GEN_ONE;
                end else begin
                    n_status = ST_FULL;
                end
                if (n_status == ST_OK) begin
                    tag_we = 1'b1;
                    tag_wa = n_res_idx;
                    tag_wd = r_tag;
                    if (r_object_total != FULL_CNT) begin
                        n_object_total = r_object_total + 1'b1;
                    end
                end
            end
            OP_UNREGISTER: begin
                if (r_tag == '0) begin
                    n_status = ST_INVALID;
                end else if (!in_range || r_rd_tag != r_tag || !gen_match) begin
                    n_status = ST_STALE;
                end else begin
                    tag_we = 1'b1;
                    gen_we = 1'b1;
                    if (r_free_depth != FULL_CNT) begin
                        stk_we       = 1'b1;
                        n_free_depth = r_free_depth + 1'b1;
                    end
                    if (r_object_total != '0) begin
                        n_object_total = r_object_total - 1'b1;
                    end
                end
            end
            OP_RESOLVE: begin
                if (r_gen == '0) begin
                    n_status = ST_INVALID;
                end else if (!in_range || r_rd_tag == '0 || !gen_match) begin
                    n_status = ST_STALE;
                end else begin
                    n_res_tag = r_rd_tag;
                end
            end
            default: n_status = ST_INVALID;
        endcase
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tag_we) begin
            tag_mem[tag_wa] <= tag_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && gen_we) begin
            gen_mem[gen_wa] <= gen_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && stk_we) begin
            stk_mem[stk_wa] <= {r_idx, next_gen};
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_depth   <= '0;
            r_slots_in_use <= '0;
            r_object_total <= '0;
        end else if (i_cmd.commit) begin
            r_free_depth   <= n_free_depth;
            r_slots_in_use <= n_slots_in_use;
            r_object_total <= n_object_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_res_idx <= n_res_idx;
            r_res_gen <= n_res_gen;
            r_res_tag <= n_res_tag;
            r_live    <= n_object_total;
        end
    end

    assign o_status            = r_status;
    assign o_result_index      = r_res_idx;
    assign o_result_generation = r_res_gen;
    assign o_resolved_tag      = r_res_tag;
    assign o_live_count        = r_live;

endmodule

`default_nettype wire

FILE: rtl/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Fixed-capacity slot map handing out generational handles for object tags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: register,
//   unregister or resolve, with tag, handle index and handle generation.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   request: status, slot index, generation, resolved tag and live count.
//   When a request is taken its slot and stack reads are registered; the
//   decision is then made from that read data and the result is registered
//   on commit, which sets o_out_valid. No new request is taken until the
//   previous one has committed, as the registered read of the slot memories
//   and free stack is followed by the write-back step.
//   While a result waits under stall the next request is still taken; its
//   commit then holds until the result register is free.
//   Reset (synchronous, active low) empties the table: no live objects,
//   empty free stack, every slot at generation one. No clearing pass is
//   needed, as slots above the high-water mark are set when first used.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table
    import gh_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int GEN_BITS   = 16,
    parameter int TAG_BITS   = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_operation,
    input  wire logic [TAG_BITS-1:0]              i_object_tag,
    input  wire logic [$clog2(SLOT_COUNT)-1:0]    i_handle_index,
    input  wire logic [GEN_BITS-1:0]              i_handle_generation,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [1:0]                            o_status,
    output logic [$clog2(SLOT_COUNT)-1:0]         o_result_index,
    output logic [GEN_BITS-1:0]                   o_result_generation,
    output logic [TAG_BITS-1:0]                   o_resolved_tag,
    output logic [$clog2(SLOT_COUNT+1)-1:0]       o_live_count
);

    t_ctrl_cmd cmd;

    // sequencer
    gh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // slot memories, stack and counters
    gh_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_operation         (i_operation),
        .i_object_tag        (i_object_tag),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_status            (o_status),
        .o_result_index      (o_result_index),
        .o_result_generation (o_result_generation),
        .o_resolved_tag      (o_resolved_tag),
        .o_live_count        (o_live_count)
    );

endmodule

`default_nettype wire

FILE: rtl/gh_checker.sv
// ----------------------------------------------------------------------------
// gh_checker
// Port-level checks on the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gh_checker
    import gh_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int GEN_BITS   = 16,
    parameter int TAG_BITS   = 32
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [1:0]                    o_status,
    input wire logic [$clog2(SLOT_COUNT)-1:0] o_result_index,
    input wire logic [GEN_BITS-1:0]           o_result_generation,
    input wire logic [TAG_BITS-1:0]           o_resolved_tag,
    input wire logic [$clog2(SLOT_COUNT+1)-1:0] o_live_count
);

    // a held result keeps its status, live count and resolved tag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_live_count) && $stable(o_resolved_tag))
        else $error("held result changed");

    // a taken request keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in flight");

    // live count never exceeds the capacity
    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_live_count <= ($clog2(SLOT_COUNT+1))'(SLOT_COUNT))
        else $error("live count above capacity");

    // failed requests carry no handle or tag
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_result_index == '0
            && o_result_generation == '0 && o_resolved_tag == '0)
        else $error("failed request returned data");

endmodule

bind generational_handle_table gh_checker #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS),
    .TAG_BITS   (TAG_BITS)
) u_gh_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_status            (o_status),
    .o_result_index      (o_result_index),
    .o_result_generation (o_result_generation),
    .o_resolved_tag      (o_resolved_tag),
    .o_live_count        (o_live_count)
);

`default_nettype wire

FILE: bench/tb_generational_handle_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_table
// Self-checking bench for the generational handle table.
// A scoreboard class keeps its own copy of slot tags, generations, free stack
// and counters, and predicts each result from the accepted request. Requests
// are a short directed run over the corner cases, then random well-formed
// register / unregister / resolve traffic drawn from the live handles, mixed
// with null, stale, mismatched, out-of-range and undefined requests. Sender
// gaps and receiver stalls are random, with one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_generational_handle_table;
    import gh_pkg::*;

    localparam int SLOTS           = 64;
    localparam logic [1:0] OP_UNDEFINED = 2'd3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ITEMS    = 700;
    localparam int BLOCK_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES = 120;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [15:0] generation;
        logic [31:0] tag;
        logic [6:0]  live;
    } t_handle_result;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_PERIODIC,
        FLOW_HEAVY
    } t_flow_mode;

    // predicted table state and the results still owed by the block
    class t_handle_table_scoreboard;
        logic [31:0] slot_tag [SLOTS];
        logic [15:0] slot_gen [SLOTS];
        logic [5:0]  free_stack [SLOTS];
        int free_depth;
        int slots_in_use;
        int object_total;
        t_handle_result owed_q[$];
        int errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_tag[i]   = '0;
                slot_gen[i]   = 16'd1;
                free_stack[i] = '0;
            end
            free_depth   = 0;
            slots_in_use = 0;
            object_total = 0;
            errors       = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // random slot that currently holds an object
        function bit pick_live(output logic [5:0] idx);
            int live_q[$];
            idx = '0;
            for (int i = 0; i < slots_in_use; i++)
                if (slot_tag[i] != 0) live_q = {live_q, i};
            if (live_q.size() == 0) return 1'b0;
            idx = live_q[$urandom_range(0, live_q.size() - 1)];
            return 1'b1;
        endfunction

        // apply one accepted request and queue the result it must give
        function void note_request(logic [1:0] op, logic [31:0] tag,
                                   logic [5:0] idx, logic [15:0] gen);
            t_handle_result r;
            int slot;
            bit got;
            r = '0;
            r.status = ST_OK;
            slot = 0;
            got = 1'b0;
            case (op)
                OP_REGISTER: begin
                    if (tag == 0) begin
                        r.status = ST_INVALID;
                    end else begin
                        if (free_depth > 0) begin
                            free_depth--;
                            slot = free_stack[free_depth];
                            got = 1'b1;
                        end else if (slots_in_use < SLOTS) begin
                            slot = slots_in_use;
                            slots_in_use++;
                            got = 1'b1;
                        end
                        if (!got) begin
                            r.status = ST_FULL;
                        end else begin
                            slot_tag[slot] = tag;
                            r.index = slot;
                            r.generation = slot_gen[slot];
                            object_total++;
                        end
                    end
                end
                OP_UNREGISTER: begin
                    if (tag == 0) begin
                        r.status = ST_INVALID;
                    end else if (idx >= slots_in_use) begin
                        r.status = ST_STALE;
                    end else if (slot_tag[idx] != tag || slot_gen[idx] != gen) begin
                        r.status = ST_STALE;
                    end else begin
                        slot_tag[idx] = '0;
                        // generation moves on, never landing on zero
                        slot_gen[idx] = slot_gen[idx] + 16'd1;
                        if (slot_gen[idx] == 0) slot_gen[idx] = 16'd1;
                        free_stack[free_depth] = idx;
                        free_depth++;
                        object_total--;
                    end
                end
                OP_RESOLVE: begin
                    if (gen == 0) begin
                        r.status = ST_INVALID;
                    end else if (idx >= slots_in_use) begin
                        r.status = ST_STALE;
                    end else if (slot_tag[idx] == 0 || slot_gen[idx] != gen) begin
                        r.status = ST_STALE;
                    end else begin
                        r.tag = slot_tag[idx];
                    end
                end
                default: r.status = ST_INVALID;
            endcase
            r.live = object_total;
            owed_q = {owed_q, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_handle_result seen);
            t_handle_result want;
            if (owed_q.size() == 0) begin
                $display("%0t: result with nothing owed, status %0h tag %0h",
                         $time, seen.status, seen.tag);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("status", want.status, seen.status);
            compare_field("result_index", want.index, seen.index);
            compare_field("result_generation", want.generation, seen.generation);
            compare_field("resolved_tag", want.tag, seen.tag);
            compare_field("live_count", want.live, seen.live);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation         = '0;
    logic [31:0] i_object_tag        = '0;
    logic [5:0]  i_handle_index      = '0;
    logic [15:0] i_handle_generation = '0;
    logic        o_out_valid;
    logic        i_out_stall         = 1'b0;
    logic [1:0]  o_status;
    logic [5:0]  o_result_index;
    logic [15:0] o_result_generation;
    logic [31:0] o_resolved_tag;
    logic [6:0]  o_live_count;

    t_handle_table_scoreboard sb = new();
    t_handle_result seen_result;
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit hold_off_req  = 1'b0;
    int hold_left     = 0;
    int mode_left     = 0;
    int flow_phase    = 0;
    t_flow_mode flow_mode = FLOW_FREE;
    int reg_bias [7]  = '{85, 85, 50, 10, 10, 50, 85};

    generational_handle_table i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_object_tag        (i_object_tag),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_result_index      (o_result_index),
        .o_result_generation (o_result_generation),
        .o_resolved_tag      (o_resolved_tag),
        .o_live_count        (o_live_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: check accepted results, stall on a pattern of its own
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_result.status     = o_status;
            seen_result.index      = o_result_index;
            seen_result.generation = o_result_generation;
            seen_result.tag        = o_resolved_tag;
            seen_result.live       = o_live_count;
            sb.check_result(seen_result);
        end
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                flow_mode = t_flow_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            flow_phase++;
            case (flow_mode)
                FLOW_FREE:     i_out_stall <= 1'b0;
                FLOW_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                FLOW_PERIODIC: i_out_stall <= flow_phase[1];
                default:       i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] nonzero_tag();
        logic [31:0] t;
        t = $urandom;
        if (t == 0) t = 32'd1;
        return t;
    endfunction

    // offer one request and hold it until taken
    task automatic offer_request(input logic [1:0] op, input logic [31:0] tag,
                                 input logic [5:0] idx, input logic [15:0] gen);
        i_in_valid          <= 1'b1;
        i_operation         <= op;
        i_object_tag        <= tag;
        i_handle_index      <= idx;
        i_handle_generation <= gen;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(op, tag, idx, gen);
    endtask

    // bursts of random length with random gaps in between
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    task automatic directed_request(input logic [1:0] op, input logic [31:0] tag,
                                    input logic [5:0] idx, input logic [15:0] gen);
        offer_request(op, tag, idx, gen);
        pace_sender();
    endtask

    // random request, mostly well formed against live handles
    task automatic make_request(input int reg_pct, output logic [1:0] op,
                                output logic [31:0] tag, output logic [5:0] idx,
                                output logic [15:0] gen);
        logic [5:0] live_idx;
        bit have_live;
        int pick;
        op   = OP_REGISTER;
        tag  = nonzero_tag();
        idx  = $urandom;
        gen  = $urandom;
        have_live = sb.pick_live(live_idx);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            op = $urandom_range(0, 1) ? OP_UNREGISTER : OP_RESOLVE;
            case ($urandom_range(0, 7))
                0: begin
                    op  = OP_REGISTER;
                    tag = '0;
                end
                1: begin
                    op  = OP_UNREGISTER;
                    tag = '0;
                end
                2: begin
                    op  = OP_RESOLVE;
                    gen = '0;
                end
                3: begin
                    op  = OP_UNDEFINED;
                    tag = $urandom;
                end
                4: begin
                    // index beyond the high-water mark
                    if (sb.slots_in_use < SLOTS)
                        idx = $urandom_range(sb.slots_in_use, SLOTS - 1);
                end
                5: begin
                    // live slot, wrong generation
                    if (have_live) begin
                        idx = live_idx;
                        tag = sb.slot_tag[idx];
                        gen = sb.slot_gen[idx] ^ 16'($urandom_range(1, 16'hFFFF));
                    end
                end
                6: begin
                    // live slot, wrong tag
                    if (have_live) begin
                        op  = OP_UNREGISTER;
                        idx = live_idx;
                        gen = sb.slot_gen[idx];
                        tag = sb.slot_tag[idx] ^ nonzero_tag();
                    end
                end
                default: begin
                    // any used slot at its current generation, often empty
                    if (sb.slots_in_use > 0) begin
                        idx = $urandom_range(0, sb.slots_in_use - 1);
                        gen = sb.slot_gen[idx];
                    end
                end
            endcase
        end else if (!have_live || pick < 15 + reg_pct * 85 / 100) begin
            op = OP_REGISTER;
        end else begin
            idx = live_idx;
            gen = sb.slot_gen[idx];
            if ($urandom_range(0, 9) < 7) begin
                op  = OP_UNREGISTER;
                tag = sb.slot_tag[idx];
            end else begin
                op  = OP_RESOLVE;
            end
        end
    endtask

    // stimulus
    initial begin
        logic [1:0]  op;
        logic [31:0] tag;
        logic [5:0]  idx;
        logic [15:0] gen;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner cases on an empty then lightly used table
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'd1);
        directed_request(OP_UNREGISTER, 32'h0,         6'd0,  16'd1);
        directed_request(OP_REGISTER,   32'h0,         6'd63, 16'hFFFF);
        directed_request(OP_UNDEFINED,  32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        directed_request(OP_REGISTER,   32'hFFFF_FFFF, 6'd0,  16'd0);
        directed_request(OP_REGISTER,   32'h0000_0001, 6'd0,  16'd0);
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'd1);
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'd0);
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'hFFFF);
        directed_request(OP_UNREGISTER, 32'h0000_0001, 6'd0,  16'd1);
        directed_request(OP_UNREGISTER, 32'hFFFF_FFFF, 6'd0,  16'd2);
        directed_request(OP_UNREGISTER, 32'h0000_0001, 6'd63, 16'd1);
        directed_request(OP_RESOLVE,    32'h0,         6'd63, 16'd1);
        directed_request(OP_UNREGISTER, 32'hFFFF_FFFF, 6'd0,  16'd1);
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'd1);
        directed_request(OP_RESOLVE,    32'h0,         6'd0,  16'd2);
        directed_request(OP_UNREGISTER, 32'h0000_0001, 6'd1,  16'd1);
        directed_request(OP_REGISTER,   32'hA5A5_5A5A, 6'd0,  16'd0);
        directed_request(OP_REGISTER,   32'h8000_0000, 6'd0,  16'd0);
        directed_request(OP_REGISTER,   32'h0000_1234, 6'd0,  16'd0);
        directed_request(OP_RESOLVE,    32'h0,         6'd2,  16'd1);
        directed_request(OP_RESOLVE,    32'h0,         6'd1,  16'd2);
        drain_results();

        // random traffic, filling and emptying the table block by block
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                hold_off_req = 1'b1;
                burst_left = 60;
            end
            make_request(reg_bias[i / BLOCK_ITEMS], op, tag, idx, gen);
            offer_request(op, tag, idx, gen);
            if (i % BLOCK_ITEMS == BLOCK_ITEMS - 1)
                drain_results();
            else
                pace_sender();
        end

        // allow any stray result to show up
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gh_pkg.sv
rtl/gh_ctrl.sv
rtl/gh_dpath.sv
rtl/generational_handle_table.sv
rtl/gh_checker.sv
bench/tb_generational_handle_table.sv
